// File: rtl/cpp_pkg.sv
`default_nettype none
package cpp_pkg;

  localparam int TONE_MAX = 31;

  localparam int DIST_W = 18;
  localparam logic [DIST_W-1:0] DIST_NONE = '1;

  // serial divider sizes
  localparam int DIV_W = 29;
  localparam int DSR_W = 10;

  // reciprocal of 2*(levels-1), scaled by 2**RCP_SHIFT
  localparam int RCP_W = 28;
  localparam int RCP_SHIFT = 28;

  // ceil(2**27 / 510), exact for dividends below 2**18
  localparam logic [18:0] RCP_510 = 19'd263173;
  localparam int RCP_510_SHIFT = 27;

  localparam logic [8:0] TONE_OFS = 9'd357;

  localparam logic [2:0] CFG_ALPHA_EN      = 3'd0;
  localparam logic [2:0] CFG_MODE          = 3'd1;
  localparam logic [2:0] CFG_PALETTE_COUNT = 3'd2;
  localparam logic [2:0] CFG_TONE_BASE     = 3'd3;
  localparam logic [2:0] CFG_TONE_LEVELS   = 3'd4;
  localparam logic [2:0] CFG_LEVELS_RED    = 3'd5;
  localparam logic [2:0] CFG_LEVELS_GREEN  = 3'd6;
  localparam logic [2:0] CFG_LEVELS_BLUE   = 3'd7;

  localparam logic [1:0] MODE_PASS    = 2'd0;
  localparam logic [1:0] MODE_PALETTE = 2'd1;
  localparam logic [1:0] MODE_TONE    = 2'd2;
  localparam logic [1:0] MODE_LEVELS  = 2'd3;

  localparam logic OP_PROJECT = 1'b0;
  localparam logic OP_WRITE   = 1'b1;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_SEARCH,
    KIND_QUANT
  } kind_t;

  typedef struct packed {
    logic             alpha_en;
    logic [1:0]       mode;
    logic [4:0]       palette_count;
    logic [23:0]      tone_base;
    logic [4:0]       tone_levels;
    logic [8:0]       levels_red;
    logic [8:0]       levels_green;
    logic [8:0]       levels_blue;
    logic [RCP_W-1:0] recip_red;
    logic [RCP_W-1:0] recip_green;
    logic [RCP_W-1:0] recip_blue;
    logic             busy;
  } ctrl_t;

  typedef struct packed {
    kind_t       kind;
    logic [23:0] rgb;
    logic [7:0]  alpha;
  } side_t;

  function automatic logic [DIST_W-1:0] sq_dist(input logic [23:0] a, input logic [23:0] b);
    logic [DIST_W-1:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] d;
    acc = '0;
    for (int s = 0; s < 3; s++) begin
      x = a[8*s +: 8];
      y = b[8*s +: 8];
      d = (x > y) ? (x - y) : (y - x);
      acc = acc + DIST_W'({8'd0, d} * {8'd0, d});
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

// File: rtl/color_palette_projector.sv
`default_nettype none
// channel  dir  handshake                   payload
// in       in   in_tvalid / in_tready       in_tdata, in_tuser (operation)
// out      out  out_tvalid / out_tready     out_tdata
// cfg      in   cfg_valid / cfg_ready       cfg_index, cfg_data
//
// one item per clock unless the output stalls or the tables are rebuilt; a pixel
// passes from the distance stage, loaded at the accepting edge, through each
// registered level of the minimum tree to the output register.
// palette writes give no result.
// after reset and after a write to tone_base, tone_levels or a levels register the
// tone table and level reciprocals are rebuilt by one shared serial divider:
// 3 divisions, plus 3*tone_levels more when tone_levels is at least 2, with
// in_tready low throughout. every stage holds while the next one is full and
// stalled, so nothing is dropped or repeated.
module color_palette_projector import cpp_pkg::*; #(
  parameter int PALETTE_SIZE = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // entry_index, in_red, in_green, in_blue, in_alpha
  input  wire logic        in_tuser,   // operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // out_red, out_green, out_blue, out_alpha
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  localparam int LANES = (PALETTE_SIZE > TONE_MAX) ? PALETTE_SIZE : TONE_MAX;
  localparam int DEPTH = $clog2(LANES);
  localparam int NL    = 2**DEPTH;
  localparam int NSTG  = DEPTH + 1;
  localparam int QSTG  = 4;

  ctrl_t       ctrl;
  logic [23:0] tone [TONE_MAX];

  logic [3:0]  in_idx;
  logic [23:0] pix;
  logic [7:0]  in_a;
  logic        acc;
  logic        pix_acc;
  logic        pal_we;

  logic [23:0] pal_r [PALETTE_SIZE];

  logic [DIST_W-1:0] lane_d_r [NL];
  logic [23:0]       lane_c_r [NL];

  logic [NSTG:1] v_r;
  logic [NSTG:1] adv;
  side_t         side_r [1:NSTG];
  side_t         side0;

  logic [23:0] qrgb;
  logic [23:0] best;
  logic [23:0] rgb_o;

  cpp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .tone      (tone)
  );

  assign cfg_ready = 1'b1;

  assign in_idx = in_tdata[3:0];
  assign pix    = {in_tdata[11:4], in_tdata[19:12], in_tdata[27:20]};
  assign in_a   = in_tdata[35:28];

  always_comb begin
    adv[NSTG] = !v_r[NSTG] || out_tready;
    for (int k = NSTG - 1; k >= 1; k--) adv[k] = !v_r[k] || adv[k+1];
  end

  assign in_tready = adv[1] && !ctrl.busy;
  assign acc       = in_tvalid && in_tready;
  assign pix_acc   = acc && (in_tuser == OP_PROJECT);
  assign pal_we    = acc && (in_tuser == OP_WRITE);

  always_ff @(posedge clk) begin
    for (int j = 0; j < PALETTE_SIZE; j++) begin
      if (pal_we && (32'(in_idx) == j)) pal_r[j] <= pix;
    end
  end

  for (genvar j = 0; j < NL; j++) begin : g_lane
    logic [23:0] pc;
    logic [23:0] tc;
    logic        pv;
    logic        tv;
    logic [23:0] col;
    logic        ok;
    if (j < PALETTE_SIZE) begin : g_pal
      assign pc = pal_r[j];
      assign pv = 32'(ctrl.palette_count) > j;
    end else begin : g_nopal
      assign pc = '0;
      assign pv = 1'b0;
    end
    if (j < TONE_MAX) begin : g_tone
      assign tc = tone[j];
      assign tv = 32'(ctrl.tone_levels) > j;
    end else begin : g_notone
      assign tc = '0;
      assign tv = 1'b0;
    end
    assign col = (ctrl.mode == MODE_PALETTE) ? pc : tc;
    assign ok  = (ctrl.mode == MODE_PALETTE) ? pv : tv;
    always_ff @(posedge clk) begin
      if (adv[1]) begin
        lane_d_r[j] <= ok ? sq_dist(pix, col) : DIST_NONE;
        lane_c_r[j] <= col;
      end
    end
  end

  always_comb begin
    side0.kind  = KIND_PASS;
    side0.rgb   = pix;
    side0.alpha = ctrl.alpha_en ? in_a : 8'hFF;
    unique case (ctrl.mode)
      MODE_PASS: begin
      end
      MODE_PALETTE: begin
        if (ctrl.palette_count != 5'd0) side0.kind = KIND_SEARCH;
      end
      MODE_TONE: begin
        if (ctrl.tone_levels == 5'd1) side0.rgb = ctrl.tone_base;
        else if (ctrl.tone_levels > 5'd1) side0.kind = KIND_SEARCH;
      end
      MODE_LEVELS: side0.kind = KIND_QUANT;
      default: side0.kind = KIND_PASS;
    endcase
  end

  cpp_quant u_quant (
    .clk     (clk),
    .en      (adv[QSTG:1]),
    .rgb_in  (pix),
    .ctrl    (ctrl),
    .rgb_out (qrgb)
  );

  cpp_mintree #(.DEPTH(DEPTH)) u_tree (
    .clk     (clk),
    .en      (adv[NSTG:2]),
    .dist_in (lane_d_r),
    .col_in  (lane_c_r),
    .best    (best)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[1]) v_r[1] <= pix_acc;
      for (int k = 2; k <= NSTG; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) side_r[1] <= side0;
    for (int k = 2; k <= NSTG; k++) begin
      if (adv[k]) begin
        // quantizer result joins the sideband once it is ready
        if (k == QSTG + 1 && side_r[k-1].kind == KIND_QUANT) begin
          side_r[k].kind  <= KIND_PASS;
          side_r[k].rgb   <= qrgb;
          side_r[k].alpha <= side_r[k-1].alpha;
        end else begin
          side_r[k] <= side_r[k-1];
        end
      end
    end
  end

  assign rgb_o      = (side_r[NSTG].kind == KIND_SEARCH) ? best : side_r[NSTG].rgb;
  assign out_tvalid = v_r[NSTG];
  assign out_tdata  = {side_r[NSTG].alpha, rgb_o[7:0], rgb_o[15:8], rgb_o[23:16]};

endmodule
`default_nettype wire

// File: rtl/cpp_ctrl.sv
`default_nettype none
module cpp_ctrl import cpp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  output ctrl_t            ctrl,
  output logic [23:0]      tone [TONE_MAX]
);

  typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_DIV} st_t;

  logic             alpha_en_r;
  logic [1:0]       mode_r;
  logic [4:0]       palette_count_r;
  logic [23:0]      tone_base_r;
  logic [4:0]       tone_levels_r;
  logic [8:0]       levels_red_r;
  logic [8:0]       levels_green_r;
  logic [8:0]       levels_blue_r;

  st_t              state_r;
  logic             tone_ph_r;
  logic [1:0]       chan_r;
  logic [4:0]       entry_r;
  logic [4:0]       step_r;
  logic [DIV_W-1:0] quo_r;
  logic [DSR_W-1:0] rem_r;
  logic [DSR_W-1:0] dsr_r;
  logic [RCP_W-1:0] rcp_r [3];
  logic [23:0]      tone_r [TONE_MAX];

  logic             restart;
  logic [8:0]       lv_sel;
  logic [8:0]       lv_m1;
  logic [DSR_W-1:0] rcp_dsr;
  logic [DIV_W-1:0] rcp_dvd;
  logic [7:0]       base_ch;
  logic [4:0]       lm1;
  logic [6:0]       wgt;
  logic [4:0]       rev;
  logic [15:0]      num;
  logic [6:0]       den;
  logic [DIV_W-1:0] tone_dvd;
  logic [DSR_W-1:0] tone_dsr;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             ge;
  logic [DSR_W-1:0] rem_nxt;
  logic [DIV_W-1:0] quo_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_en_r      <= 1'b1;
      mode_r          <= MODE_PASS;
      palette_count_r <= 5'd0;
      tone_base_r     <= 24'hFFFFFF;
      tone_levels_r   <= 5'd0;
      levels_red_r    <= 9'd256;
      levels_green_r  <= 9'd256;
      levels_blue_r   <= 9'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ALPHA_EN:      alpha_en_r      <= cfg_data[0];
        CFG_MODE:          mode_r          <= cfg_data[1:0];
        CFG_PALETTE_COUNT: palette_count_r <= cfg_data[4:0];
        CFG_TONE_BASE:     tone_base_r     <= cfg_data;
        CFG_TONE_LEVELS:   tone_levels_r   <= cfg_data[4:0];
        CFG_LEVELS_RED:    levels_red_r    <= cfg_data[8:0];
        CFG_LEVELS_GREEN:  levels_green_r  <= cfg_data[8:0];
        CFG_LEVELS_BLUE:   levels_blue_r   <= cfg_data[8:0];
      endcase
    end
  end

  // any write that changes a derived table starts the rebuild over
  assign restart = cfg_valid && (cfg_index == CFG_TONE_BASE || cfg_index == CFG_TONE_LEVELS ||
                                 cfg_index == CFG_LEVELS_RED || cfg_index == CFG_LEVELS_GREEN ||
                                 cfg_index == CFG_LEVELS_BLUE);

  // channel 0 is blue, 2 is red
  always_comb begin
    unique case (chan_r)
      2'd0:    begin lv_sel = levels_blue_r;  base_ch = tone_base_r[7:0];   end
      2'd1:    begin lv_sel = levels_green_r; base_ch = tone_base_r[15:8];  end
      2'd2:    begin lv_sel = levels_red_r;   base_ch = tone_base_r[23:16]; end
      default: begin lv_sel = levels_red_r;   base_ch = tone_base_r[23:16]; end
    endcase
    lv_m1    = lv_sel - 9'd1;
    rcp_dsr  = {lv_m1, 1'b0};
    rcp_dvd  = (DIV_W'(1) << RCP_SHIFT) + DIV_W'(rcp_dsr) - DIV_W'(1);
    lm1      = tone_levels_r - 5'd1;
    wgt      = 7'(lm1) + 7'(entry_r) * 7'd3;
    rev      = lm1 - entry_r;
    num      = 16'(base_ch) * 16'(wgt) + 16'(TONE_OFS) * 16'(rev);
    den      = {lm1, 2'b00};
    tone_dvd = DIV_W'({num, 1'b0}) + DIV_W'(den);
    tone_dsr = DSR_W'({den, 1'b0});
    trial    = {rem_r, quo_r[DIV_W-1]};
    diff     = trial - {1'b0, dsr_r};
    ge       = trial >= {1'b0, dsr_r};
    rem_nxt  = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
    quo_nxt  = {quo_r[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      tone_ph_r <= 1'b0;
      chan_r    <= 2'd0;
      entry_r   <= 5'd0;
    end else if (restart) begin
      state_r   <= ST_LOAD;
      tone_ph_r <= 1'b0;
      chan_r    <= 2'd0;
      entry_r   <= 5'd0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
        end
        ST_LOAD: begin
          quo_r   <= tone_ph_r ? tone_dvd : rcp_dvd;
          dsr_r   <= tone_ph_r ? tone_dsr : rcp_dsr;
          rem_r   <= '0;
          step_r  <= 5'd0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          quo_r  <= quo_nxt;
          rem_r  <= rem_nxt;
          step_r <= step_r + 5'd1;
          if (step_r == 5'(DIV_W - 1)) begin
            if (!tone_ph_r) begin
              rcp_r[chan_r] <= quo_nxt[RCP_W-1:0];
            end else begin
              tone_r[entry_r][{chan_r, 3'b000} +: 8] <=
                (quo_nxt > DIV_W'(255)) ? 8'hFF : quo_nxt[7:0];
            end
            if (chan_r != 2'd2) begin
              chan_r  <= chan_r + 2'd1;
              state_r <= ST_LOAD;
            end else begin
              chan_r <= 2'd0;
              if (!tone_ph_r) begin
                if (tone_levels_r >= 5'd2) begin
                  tone_ph_r <= 1'b1;
                  entry_r   <= 5'd0;
                  state_r   <= ST_LOAD;
                end else begin
                  state_r <= ST_IDLE;
                end
              end else if (entry_r == lm1) begin
                state_r <= ST_IDLE;
              end else begin
                entry_r <= entry_r + 5'd1;
                state_r <= ST_LOAD;
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    ctrl.alpha_en      = alpha_en_r;
    ctrl.mode          = mode_r;
    ctrl.palette_count = palette_count_r;
    ctrl.tone_base     = tone_base_r;
    ctrl.tone_levels   = tone_levels_r;
    ctrl.levels_red    = levels_red_r;
    ctrl.levels_green  = levels_green_r;
    ctrl.levels_blue   = levels_blue_r;
    ctrl.recip_red     = rcp_r[2];
    ctrl.recip_green   = rcp_r[1];
    ctrl.recip_blue    = rcp_r[0];
    ctrl.busy          = state_r != ST_IDLE;
  end

  assign tone = tone_r;

endmodule
`default_nettype wire

// File: rtl/cpp_quant.sv
`default_nettype none
module cpp_quant import cpp_pkg::*; (
  input  wire logic        clk,
  input  wire logic [3:0]  en,
  input  wire logic [23:0] rgb_in,
  input  wire ctrl_t       ctrl,
  output logic [23:0]      rgb_out
);

  logic [8:0]       lv  [3];
  logic [RCP_W-1:0] rcp [3];
  logic [8:0]       nm1 [3];

  logic [17:0] x1_r   [3];
  logic [8:0]  step_r [3];
  logic [17:0] x2_r   [3];
  logic [7:0]  q_r    [3];

  assign lv[0]  = ctrl.levels_blue;
  assign lv[1]  = ctrl.levels_green;
  assign lv[2]  = ctrl.levels_red;
  assign rcp[0] = ctrl.recip_blue;
  assign rcp[1] = ctrl.recip_green;
  assign rcp[2] = ctrl.recip_red;

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [16:0] prod1;
    logic [36:0] prod2;
    logic [45:0] prod4;
    logic [9:0]  qf;

    assign nm1[c] = lv[c] - 9'd1;
    assign prod1  = 17'({9'd0, rgb_in[8*c +: 8]} * {8'd0, nm1[c]});
    assign prod2  = 37'(x1_r[c]) * 37'(RCP_510);
    assign prod4  = 46'(x2_r[c]) * 46'(rcp[c]);
    assign qf     = prod4[RCP_SHIFT +: 10];

    always_ff @(posedge clk) begin
      // step = round(v*(n-1)/255), then back to the 0..255 scale
      if (en[0]) x1_r[c] <= {prod1, 1'b0} + 18'd255;
      if (en[1]) step_r[c] <= prod2[RCP_510_SHIFT +: 9];
      if (en[2]) x2_r[c] <= 18'({9'd0, step_r[c]} * 18'd510) + 18'(nm1[c]);
      if (en[3]) begin
        if (lv[c] < 9'd2) q_r[c] <= 8'd0;
        else q_r[c] <= (qf > 10'd255) ? 8'hFF : qf[7:0];
      end
    end

    assign rgb_out[8*c +: 8] = q_r[c];
  end

endmodule
`default_nettype wire

// File: rtl/cpp_mintree.sv
`default_nettype none
module cpp_mintree import cpp_pkg::*; #(
  parameter int DEPTH = 5
) (
  input  wire logic              clk,
  input  wire logic [DEPTH-1:0]  en,
  input  wire logic [DIST_W-1:0] dist_in [2**DEPTH],
  input  wire logic [23:0]       col_in  [2**DEPTH],
  output logic [23:0]            best
);

  localparam int NL = 2**DEPTH;

  // all tree levels packed one after the other, root last
  logic [DIST_W-1:0] nd_r [NL-1];
  logic [23:0]       nc_r [NL-1];

  for (genvar l = 0; l < DEPTH; l++) begin : g_lvl
    localparam int CNT  = NL >> (l + 1);
    localparam int OFS  = NL - (NL >> l);
    localparam int PREV = NL - 2 * (NL >> l);
    for (genvar k = 0; k < CNT; k++) begin : g_node
      logic [DIST_W-1:0] da;
      logic [DIST_W-1:0] db;
      logic [23:0]       ca;
      logic [23:0]       cb;
      if (l == 0) begin : g_leaf
        assign da = dist_in[2*k];
        assign db = dist_in[2*k+1];
        assign ca = col_in[2*k];
        assign cb = col_in[2*k+1];
      end else begin : g_inner
        assign da = nd_r[PREV+2*k];
        assign db = nd_r[PREV+2*k+1];
        assign ca = nc_r[PREV+2*k];
        assign cb = nc_r[PREV+2*k+1];
      end
      // lower index keeps a tie
      always_ff @(posedge clk) begin
        if (en[l]) begin
          if (db < da) begin
            nd_r[OFS+k] <= db;
            nc_r[OFS+k] <= cb;
          end else begin
            nd_r[OFS+k] <= da;
            nc_r[OFS+k] <= ca;
          end
        end
      end
    end
  end

  assign best = nc_r[NL-2];

endmodule
`default_nettype wire
